// ----- design/dapp_pkg.sv -----
// Shared types, character codes and constants of the dotted address and port parser.
`timescale 1ns / 1ps
package dapp_pkg;

	localparam int unsigned MAX_LENGTH_DEF = 2048;

	localparam int TEXT_W   = 8;
	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 16;
	localparam int OFFSET_W = 11;

	localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = 16'd1000;
	localparam logic [PORT_W-1:0] PORT_MAX         = 16'hFFFF;
	localparam logic [7:0]        OCTET_MAX        = 8'd255;

	localparam logic [TEXT_W-1:0] CH_NUL   = 8'h00;
	localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
	localparam logic [TEXT_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [TEXT_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;
	localparam logic [TEXT_W-1:0] CH_COLON = 8'h3A;

	localparam logic [1:0] LAST_OCTET = 2'd3;

	typedef enum logic [4:0] {
		PH_DIGIT  = 5'b00001,
		PH_NUMBER = 5'b00010,
		PH_SKIP   = 5'b00100,
		PH_TAIL   = 5'b01000,
		PH_FAIL   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic space;
		logic dash_sp;
		logic colon;
		logic dash_co;
		logic port_dig;
		logic port_done;
		logic ended;
	} flags_t;

	typedef struct packed {
		phase_t             phase;
		logic [1:0]         octet_idx;
		logic [7:0]         octet_acc;
		logic [ADDR_W-1:0]  address;
		logic [PORT_W-1:0]  port_acc;
		flags_t             flags;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{
		phase:     PH_DIGIT,
		octet_idx: 2'd0,
		octet_acc: 8'd0,
		address:   32'd0,
		port_acc:  16'd0,
		flags:     7'd0
	};

	function automatic logic is_digit(input logic [TEXT_W-1:0] c);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// ----- design/dapp_text_if.sv -----
// Input channel: one character of the command string with its last-byte mark.
`timescale 1ns / 1ps
interface dapp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

// ----- design/dapp_result_if.sv -----
// Output channel: one parse result per command string.
`timescale 1ns / 1ps
interface dapp_result_if;
	logic        valid;
	logic        ready;
	logic        parse_ok;
	logic [31:0] ipv4_address;
	logic [15:0] port_number;
	logic [10:0] payload_offset;

	modport source (output valid, output parse_ok, output ipv4_address,
		output port_number, output payload_offset, input ready);
	modport sink (input valid, input parse_ok, input ipv4_address,
		input port_number, input payload_offset, output ready);
endinterface

// ----- design/dotted_address_port_parser_top.sv -----
// Top level of the dotted address and port parser: input stage, parse state, result register.
//
//   channel   dir  payload                                         handshake
//   text      in   text_byte[7:0], last_byte                       valid/ready
//   result    out  parse_ok, ipv4_address[31:0], port_number[15:0],
//                  payload_offset[10:0]                            valid/ready
//   cfg       in   cfg_wr_data[15:0] (default_port)                cfg_wr_en
//
// One character per cycle. An accepted item is registered in the input stage,
// then updates the parse state; the item carrying the last-byte mark loads the
// result register when it leaves the input stage. arst_n clears all control state
// and sets default_port to 1000; no clearing pass. A stalled result holds the
// last-marked item in the input stage and stops the input while it waits;
// characters ahead of it keep flowing.
`timescale 1ns / 1ps
module dotted_address_port_parser_top #(
	parameter int unsigned MAX_LENGTH = dapp_pkg::MAX_LENGTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dapp_text_if.sink                      text,
	dapp_result_if.source                  result,
	input  logic                           cfg_wr_en,
	input  logic [dapp_pkg::PORT_W-1:0]    cfg_wr_data
);
	import dapp_pkg::*;

	localparam int POS_W = $clog2(MAX_LENGTH + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LENGTH);

	logic [PORT_W-1:0]   default_port_q;

	logic                s1_valid_s1;
	logic [TEXT_W-1:0]   byte_s1;
	logic                last_s1;

	parse_t              st_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    dsp_pos_q;
	logic [POS_W-1:0]    dco_pos_q;

	logic                out_valid_q;
	logic                ok_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [PORT_W-1:0]   port_q;
	logic [OFFSET_W-1:0] off_q;

	logic                out_free;
	logic                s1_go;
	logic                at_limit;
	logic                take;
	logic                stop;
	parse_t              st_nxt;
	parse_t              st_after;
	logic [POS_W-1:0]    dsp_nxt;
	logic [POS_W-1:0]    dco_nxt;
	logic [POS_W-1:0]    dsp_after;
	logic [POS_W-1:0]    dco_after;
	logic [POS_W-1:0]    pos_after;
	logic                ok_res;
	logic [PORT_W-1:0]   port_res;
	logic [POS_W-1:0]    off_sel;
	logic [POS_W+OFFSET_W-1:0] off_wide;

	assign out_free   = !out_valid_q || result.ready;
	assign s1_go      = s1_valid_s1 && (!last_s1 || out_free);
	assign text.ready = !s1_valid_s1 || s1_go;

	assign at_limit = pos_q >= POS_LIMIT;
	assign take     = !st_q.flags.ended && !at_limit && (byte_s1 != CH_NUL);
	assign stop     = !st_q.flags.ended && (at_limit || (byte_s1 == CH_NUL));

	dapp_consume #(
		.POS_W (POS_W)
	) u_consume (
		.cur         (st_q),
		.c           (byte_s1),
		.pos         (pos_q),
		.dsp_pos     (dsp_pos_q),
		.dco_pos     (dco_pos_q),
		.nxt         (st_nxt),
		.nxt_dsp_pos (dsp_nxt),
		.nxt_dco_pos (dco_nxt)
	);

	always_comb begin
		st_after  = take ? st_nxt : st_q;
		dsp_after = take ? dsp_nxt : dsp_pos_q;
		dco_after = take ? dco_nxt : dco_pos_q;
		pos_after = take ? pos_q + POS_W'(1) : pos_q;
		if (stop) begin
			st_after.flags.ended = 1'b1;
		end
	end

	always_comb begin
		ok_res   = 1'b0;
		port_res = '0;
		off_sel  = '0;
		if ((st_after.phase == PH_NUMBER && st_after.octet_idx == LAST_OCTET)
				|| st_after.phase == PH_TAIL) begin
			if (st_after.flags.colon) begin
				ok_res   = st_after.flags.port_dig && st_after.flags.dash_co;
				port_res = st_after.port_acc;
				off_sel  = dco_after;
			end else begin
				ok_res   = st_after.flags.space && st_after.flags.dash_sp;
				port_res = default_port_q;
				off_sel  = dsp_after;
			end
		end
	end

	assign off_wide = {{OFFSET_W{1'b0}}, off_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_port_q <= DEFAULT_PORT_RST;
		end else if (cfg_wr_en) begin
			default_port_q <= cfg_wr_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (text.ready) begin
			s1_valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.last_byte;
		end
	end

	// parse state: clear after the last-marked item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= PARSE_CLEAR;
			pos_q     <= '0;
			dsp_pos_q <= '0;
			dco_pos_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				st_q      <= PARSE_CLEAR;
				pos_q     <= '0;
				dsp_pos_q <= '0;
				dco_pos_q <= '0;
			end else begin
				st_q      <= st_after;
				pos_q     <= pos_after;
				dsp_pos_q <= dsp_after;
				dco_pos_q <= dco_after;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// failed parses report zero fields
	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			ok_q   <= ok_res;
			addr_q <= ok_res ? st_after.address : '0;
			port_q <= ok_res ? port_res : '0;
			off_q  <= ok_res ? off_wide[OFFSET_W-1:0] : '0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.parse_ok       = ok_q;
	assign result.ipv4_address   = addr_q;
	assign result.port_number    = port_q;
	assign result.payload_offset = off_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> addr_q == '0 && port_q == '0 && off_q == '0)
		else $error("failed parse carries nonzero fields");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> pos_q == '0 && st_q.phase == PH_DIGIT && !st_q.flags.ended)
		else $error("parse state not cleared after last item");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LIMIT)
		else $error("byte position beyond limit");

	a_port_needs_colon: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.flags.port_dig || st_q.flags.port_done || st_q.flags.dash_co)
		|-> st_q.flags.colon)
		else $error("port search flags set without colon");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && last_s1 && !out_free |=> s1_valid_s1 && last_s1)
		else $error("last item dropped while result stalled");

endmodule

// ----- design/dapp_consume.sv -----
// Next-state logic for one character: octet digits, dot skipping, port and dash search.
`timescale 1ns / 1ps
module dapp_consume #(
	parameter int POS_W = 12
) (
	input  dapp_pkg::parse_t    cur,
	input  logic [7:0]          c,
	input  logic [POS_W-1:0]    pos,
	input  logic [POS_W-1:0]    dsp_pos,
	input  logic [POS_W-1:0]    dco_pos,
	output dapp_pkg::parse_t    nxt,
	output logic [POS_W-1:0]    nxt_dsp_pos,
	output logic [POS_W-1:0]    nxt_dco_pos
);
	import dapp_pkg::*;

	logic        digit;
	logic [3:0]  dval;
	logic [11:0] oct_sum;
	logic [19:0] port_sum;
	logic        do_tail;

	assign digit = is_digit(c);
	assign dval  = c[3:0];

	// acc * 10 + digit as two shifted adds
	assign oct_sum = {1'b0, cur.octet_acc, 3'b000} + {3'b000, cur.octet_acc, 1'b0}
		+ {8'd0, dval};
	assign port_sum = {1'b0, cur.port_acc, 3'b000} + {3'b000, cur.port_acc, 1'b0}
		+ {16'd0, dval};

	always_comb begin
		nxt         = cur;
		nxt_dsp_pos = dsp_pos;
		nxt_dco_pos = dco_pos;
		do_tail     = 1'b0;

		unique case (cur.phase)
			PH_DIGIT: begin
				if (digit) begin
					nxt.octet_acc = {4'd0, dval};
					nxt.address[cur.octet_idx*8 +: 8] = {4'd0, dval};
					nxt.phase = PH_NUMBER;
				end else begin
					nxt.phase = PH_FAIL;
				end
			end
			PH_NUMBER: begin
				if (digit) begin
					if (oct_sum > {4'd0, OCTET_MAX}) begin
						nxt.phase = PH_FAIL;
					end else begin
						nxt.octet_acc = oct_sum[7:0];
						nxt.address[cur.octet_idx*8 +: 8] = oct_sum[7:0];
					end
				end else if (cur.octet_idx == LAST_OCTET) begin
					nxt.phase = PH_TAIL;
					do_tail   = 1'b1;
				end else if (c == CH_DOT) begin
					nxt.phase     = PH_DIGIT;
					nxt.octet_idx = cur.octet_idx + 2'd1;
				end else begin
					nxt.phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (c == CH_DOT) begin
					nxt.phase     = PH_DIGIT;
					nxt.octet_idx = cur.octet_idx + 2'd1;
				end
			end
			PH_TAIL: begin
				do_tail = 1'b1;
			end
			PH_FAIL: begin
				nxt = cur;
			end
			default: begin
				nxt = cur;
			end
		endcase

		if (do_tail) begin
			if (cur.flags.colon) begin
				if (!cur.flags.port_done) begin
					if (!cur.flags.port_dig) begin
						if (digit) begin
							nxt.flags.port_dig = 1'b1;
							nxt.port_acc = {12'd0, dval};
						end else begin
							nxt.flags.port_done = 1'b1;
						end
					end else if (digit) begin
						if (port_sum > {4'd0, PORT_MAX}) begin
							nxt.phase = PH_FAIL;
						end else begin
							nxt.port_acc = port_sum[15:0];
						end
					end else begin
						nxt.flags.port_done = 1'b1;
					end
				end
				if (c == CH_DASH && !cur.flags.dash_co) begin
					nxt.flags.dash_co = 1'b1;
					nxt_dco_pos = pos;
				end
			end
			if (cur.flags.space && c == CH_DASH && !cur.flags.dash_sp) begin
				nxt.flags.dash_sp = 1'b1;
				nxt_dsp_pos = pos;
			end
			if (c == CH_COLON && !cur.flags.colon) begin
				nxt.flags.colon = 1'b1;
			end
			if (c == CH_SPACE && !cur.flags.space) begin
				nxt.flags.space = 1'b1;
			end
		end
	end

endmodule

// ----- test/tb_dotted_address_port_parser_top.sv -----
// Self-checking testbench for the address and port parser: directed strings, then random ones.
`timescale 1ns / 1ps
module tb_dotted_address_port_parser_top;
	import dapp_pkg::*;

	localparam int unsigned TB_MAX_LEN     = MAX_LENGTH_DEF;
	localparam int          RESET_CYCLES   = 12;
	localparam int          SETTLE_CYCLES  = 4;
	localparam int          END_CYCLES     = 16;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          MAX_REPORTS    = 10;
	localparam int          DIR_ROWS       = 24;
	localparam int          CFG_PHASES     = 5;
	localparam int          PHASE_BYTES    = 24;
	localparam int          PHASE_STRINGS  = 1;

	typedef struct packed {
		logic                ok;
		logic [ADDR_W-1:0]   addr;
		logic [PORT_W-1:0]   port;
		logic [OFFSET_W-1:0] off;
	} parse_res_t;

	localparam parse_res_t FAIL_RES = '0;

	typedef enum logic [1:0] {ROW_PLAIN, ROW_NUL} row_kind_t;

	typedef struct {
		string      txt;
		row_kind_t  kind;
		bit         typed;
		parse_res_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [PORT_W-1:0] cfg_wr_data;

	dapp_text_if   text_ch();
	dapp_result_if result_ch();

	dotted_address_port_parser_top #(
		.MAX_LENGTH(TB_MAX_LEN)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.result     (result_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Parser state as the block should hold it
	phase_t              p_phase;
	logic [1:0]          p_oct_idx;
	logic [8:0]          p_oct_acc;
	logic [ADDR_W-1:0]   p_addr;
	logic [16:0]         p_port_acc;
	logic [11:0]         p_pos;
	flags_t              p_flags;
	logic [OFFSET_W-1:0] p_dash_sp;
	logic [OFFSET_W-1:0] p_dash_co;
	logic [PORT_W-1:0]   p_dflt_port;

	parse_res_t   awaited_results[$];
	logic [7:0]   text_buf[$];
	dir_row_t     dir_tab[DIR_ROWS];
	int           mismatch_cnt = 0;
	int           burst_left = 0;
	int           quiet_cycles = 0;
	string        junk_chars = " abz-:/x";
	string        noise_chars = "0123456789.: -";

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_num(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic void clear_parse_state();
		p_phase    = PH_DIGIT;
		p_oct_idx  = '0;
		p_oct_acc  = '0;
		p_addr     = '0;
		p_port_acc = '0;
		p_pos      = '0;
		p_flags    = '0;
		p_dash_sp  = '0;
		p_dash_co  = '0;
	endfunction

	function automatic void store_octet();
		p_addr[p_oct_idx*8 +: 8] = p_oct_acc[7:0];
	endfunction

	// Colon and space searches, port digits, dash positions after the fourth octet
	function automatic void tail_char(logic [7:0] c);
		bit colon_seen;
		bit space_seen;
		logic [19:0] port_nx;
		colon_seen = p_flags.colon;
		space_seen = p_flags.space;
		if (colon_seen) begin
			if (!p_flags.port_done) begin
				if (!is_num(c)) begin
					p_flags.port_done = 1'b1;
				end else if (!p_flags.port_dig) begin
					p_flags.port_dig = 1'b1;
					p_port_acc = 17'(c - CH_ZERO);
				end else begin
					port_nx = 20'(p_port_acc) * 20'd10 + 20'(c - CH_ZERO);
					if (port_nx > 20'(PORT_MAX)) begin
						p_phase = PH_FAIL;
						return;
					end
					p_port_acc = port_nx[16:0];
				end
			end
			if (c == CH_DASH && !p_flags.dash_co) begin
				p_flags.dash_co = 1'b1;
				p_dash_co = p_pos[OFFSET_W-1:0];
			end
		end
		if (space_seen && c == CH_DASH && !p_flags.dash_sp) begin
			p_flags.dash_sp = 1'b1;
			p_dash_sp = p_pos[OFFSET_W-1:0];
		end
		if (c == CH_COLON && !colon_seen)
			p_flags.colon = 1'b1;
		if (c == CH_SPACE && !space_seen)
			p_flags.space = 1'b1;
	endfunction

	task automatic predict_char(input logic [7:0] c, input logic last,
		output bit has_res, output parse_res_t res);
		logic [11:0] oct_nx;
		bit good;
		if (!p_flags.ended) begin
			if (p_pos >= 12'(TB_MAX_LEN) || c == CH_NUL) begin
				p_flags.ended = 1'b1;
			end else begin
				case (p_phase)
					PH_DIGIT: begin
						if (is_num(c)) begin
							p_oct_acc = 9'(c - CH_ZERO);
							store_octet();
							p_phase = PH_NUMBER;
						end else begin
							p_phase = PH_FAIL;
						end
					end
					PH_NUMBER: begin
						if (is_num(c)) begin
							oct_nx = 12'(p_oct_acc) * 12'd10 + 12'(c - CH_ZERO);
							if (oct_nx > 12'(OCTET_MAX)) begin
								p_phase = PH_FAIL;
							end else begin
								p_oct_acc = oct_nx[8:0];
								store_octet();
							end
						end else if (p_oct_idx == LAST_OCTET) begin
							p_phase = PH_TAIL;
							tail_char(c);
						end else if (c == CH_DOT) begin
							p_oct_idx = p_oct_idx + 2'd1;
							p_phase = PH_DIGIT;
						end else begin
							p_phase = PH_SKIP;
						end
					end
					PH_SKIP: begin
						if (c == CH_DOT) begin
							p_oct_idx = p_oct_idx + 2'd1;
							p_phase = PH_DIGIT;
						end
					end
					PH_TAIL: begin
						tail_char(c);
					end
					default: ;
				endcase
				p_pos = p_pos + 12'd1;
			end
		end
		has_res = last;
		res = FAIL_RES;
		if (last) begin
			good = (p_phase == PH_NUMBER && p_oct_idx == LAST_OCTET) || p_phase == PH_TAIL;
			if (good) begin
				if (p_flags.colon) begin
					good = p_flags.port_dig && p_flags.dash_co;
					res.port = p_port_acc[PORT_W-1:0];
					res.off = p_dash_co;
				end else begin
					good = p_flags.space && p_flags.dash_sp;
					res.port = p_dflt_port;
					res.off = p_dash_sp;
				end
				res.addr = p_addr;
			end
			if (good)
				res.ok = 1'b1;
			else
				res = FAIL_RES;
			clear_parse_state();
		end
	endtask

	function automatic void push_str(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endfunction

	function automatic void push_junk(int n);
		repeat (n) text_buf.push_back(junk_chars[$urandom_range(0, junk_chars.len() - 1)]);
	endfunction

	// Mostly well-formed strings with random content; some noise, some broken
	task automatic compose_random_text();
		int kind;
		int k;
		int n;
		int cut;
		int unsigned v;
		text_buf.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			n = $urandom_range(1, 10);
			repeat (n) begin
				if ($urandom_range(0, 1))
					text_buf.push_back(8'($urandom_range(0, 255)));
				else
					text_buf.push_back(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
			end
		end else begin
			for (k = 0; k < 4; k++) begin
				if ($urandom_range(0, 19) == 0)
					text_buf.push_back(CH_ZERO);
				case ($urandom_range(0, 39))
					0:       v = $urandom_range(256, 999);
					1, 2, 3: v = 0;
					4, 5, 6: v = 255;
					default: v = $urandom_range(0, 255);
				endcase
				push_str($sformatf("%0d", v));
				if ($urandom_range(0, 7) == 0)
					push_junk($urandom_range(1, 3));
				if (k < 3)
					text_buf.push_back(CH_DOT);
			end
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 5) == 0)
					push_junk($urandom_range(1, 3));
				text_buf.push_back(CH_COLON);
				if ($urandom_range(0, 11) != 0) begin
					case ($urandom_range(0, 9))
						0:       v = 0;
						1:       v = 65535;
						2:       v = $urandom_range(65536, 99999);
						3:       v = $urandom_range(0, 9);
						default: v = $urandom_range(0, 65535);
					endcase
					push_str($sformatf("%0d", v));
				end
				if ($urandom_range(0, 3) == 0)
					push_junk($urandom_range(1, 3));
			end else begin
				if ($urandom_range(0, 5) == 0)
					push_junk($urandom_range(1, 3));
				text_buf.push_back(CH_SPACE);
				if ($urandom_range(0, 3) == 0)
					push_junk($urandom_range(1, 3));
			end
			if ($urandom_range(0, 9) != 0)
				text_buf.push_back(CH_DASH);
			n = $urandom_range(0, 5);
			repeat (n) text_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
			if (kind < 25) begin
				cut = $urandom_range(0, text_buf.size() - 1);
				case ($urandom_range(0, 2))
					0: text_buf[cut] = 8'($urandom_range(0, 255));
					1: while (text_buf.size() > cut + 1) void'(text_buf.pop_back());
					default: text_buf.insert(cut, CH_NUL);
				endcase
			end
		end
	endtask

	// Drive text_buf as one string; queue the expected result on its marked item
	task automatic send_text(input bit typed, input parse_res_t typed_res);
		int i;
		int n;
		int gap;
		bit has_res;
		parse_res_t res;
		n = text_buf.size();
		for (i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
				if (gap > 0) begin
					text_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			text_ch.valid     <= 1'b1;
			text_ch.text_byte <= text_buf[i];
			text_ch.last_byte <= (i == n - 1);
			do @(posedge clk); while (!text_ch.ready);
			predict_char(text_buf[i], i == n - 1, has_res, res);
			if (has_res)
				awaited_results.push_back(typed ? typed_res : res);
		end
	endtask

	// Hold the sender until every queued result is out, then let the pipe settle
	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int r;
		int ph;
		int phase_bytes;
		int phase_strings;
		logic [PORT_W-1:0] cfg_val;
		text_ch.valid     = 1'b0;
		text_ch.text_byte = '0;
		text_ch.last_byte = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		arst_n            = 1'b0;
		p_dflt_port       = DEFAULT_PORT_RST;
		clear_parse_state();

		dir_tab = '{
			'{"1.2.3.4 -", ROW_PLAIN, 1'b1,
				'{1'b1, 32'h04030201, DEFAULT_PORT_RST, 11'd8}},
			'{"255.255.255.255:65535-", ROW_PLAIN, 1'b1,
				'{1'b1, 32'hFFFFFFFF, 16'd65535, 11'd21}},
			'{"0.0.0.0:0-", ROW_PLAIN, 1'b1, '{1'b1, 32'h0, 16'd0, 11'd9}},
			'{"256.1.1.1 -", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3.4:65536-", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3.4:999999-", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"a.1.1.1 -", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3.4", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3.4:x -", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3.4: -", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3.4-", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3.4 x", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"1.2.3.4:80 x", ROW_PLAIN, 1'b1, FAIL_RES},
			'{" 1.2.3.4 -", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"7", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"-", ROW_PLAIN, 1'b1, FAIL_RES},
			'{"12ab.34.56x.78 :9-", ROW_PLAIN, 1'b0, FAIL_RES},
			'{"1.2.3.4abc:8080 x-y", ROW_PLAIN, 1'b0, FAIL_RES},
			'{"001.02.3.4 5:6-", ROW_PLAIN, 1'b0, FAIL_RES},
			'{"1.2.3.4 -:5-", ROW_PLAIN, 1'b0, FAIL_RES},
			'{"9.8.7.6 -", ROW_NUL, 1'b0, FAIL_RES},
			'{"9.8", ROW_NUL, 1'b0, FAIL_RES},
			'{"192.168.1.77:12345-hello", ROW_PLAIN, 1'b0, FAIL_RES}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIR_ROWS; r++) begin
			text_buf.delete();
			push_str(dir_tab[r].txt);
			case (dir_tab[r].kind)
				ROW_NUL: begin
					// everything after the zero byte is dropped
					text_buf.push_back(CH_NUL);
					push_str("1:5-");
				end
				default: ;
			endcase
			send_text(dir_tab[r].typed, dir_tab[r].res);
		end

		for (ph = 0; ph < CFG_PHASES; ph++) begin
			case (ph)
				0:       cfg_val = '0;
				1:       cfg_val = PORT_MAX;
				3:       cfg_val = 16'd1;
				default: cfg_val = 16'($urandom);
			endcase
			wait_drained();
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= cfg_val;
			@(posedge clk);
			cfg_wr_en   <= 1'b0;
			p_dflt_port = cfg_val;

			phase_bytes = 0;
			phase_strings = 0;
			while (phase_bytes < PHASE_BYTES || phase_strings < PHASE_STRINGS) begin
				compose_random_text();
				if ($urandom_range(0, 11) == 0)
					wait_drained();
				phase_bytes += text_buf.size();
				phase_strings++;
				send_text(1'b0, FAIL_RES);
			end
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && awaited_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: alternating ready and stall runs, with full-rate stretches
	initial begin : receiver
		int hold_cnt;
		bit rdy_level;
		hold_cnt = 0;
		rdy_level = 1'b0;
		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_cnt == 0) begin
				if ($urandom_range(0, 9) < 2) begin
					rdy_level = 1'b1;
					hold_cnt = 60;
				end else if (rdy_level) begin
					rdy_level = 1'b0;
					hold_cnt = $urandom_range(1, 12);
				end else begin
					rdy_level = 1'b1;
					hold_cnt = $urandom_range(1, 8);
				end
			end
			result_ch.ready <= rdy_level;
			hold_cnt--;
		end
	end

	always @(posedge clk) begin : result_check
		parse_res_t got;
		parse_res_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.parse_ok, result_ch.ipv4_address, result_ch.port_number,
				result_ch.payload_offset};
			if (awaited_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("unexpected result: ok=%0b addr=%08h port=%0d off=%0d",
						got.ok, got.addr, got.port, got.off);
			end else begin
				want = awaited_results.pop_front();
				if (got.ok !== want.ok || got.addr !== want.addr ||
					got.port !== want.port || got.off !== want.off) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("mismatch: exp ok=%0b addr=%08h port=%0d off=%0d,",
							want.ok, want.addr, want.port, want.off,
							" got ok=%0b addr=%08h port=%0d off=%0d",
							got.ok, got.addr, got.port, got.off);
				end
			end
		end
	end

	// Drop out if neither channel moves an item for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
